### rtl/core/srmq_pkg.sv
// shared constants, codes and types for the sparse-table range-minimum engine
package srmq_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int LEVELS_DEF = 11;

    localparam int DATA_W     = 32;
    localparam int CNT_IN_W   = 11;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

    // item kinds carried in the slave tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result status carried in the master tuser
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // commands of the shared minimum unit
    localparam logic [1:0] MU_HOLD = 2'd0;
    localparam logic [1:0] MU_INIT = 2'd1;
    localparam logic [1:0] MU_PAIR = 2'd2;
    localparam logic [1:0] MU_FOLD = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_mu_cmd;

endpackage

### rtl/core/sparse_table_range_minimum.sv
// top level: sequencer for element writes, table build and range queries
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------
//  s_axis   | in        | tvalid / tready           | tuser op, tdata item fields
//  m_axis   | out       | tvalid / tready           | tuser status, tdata minimum
//  cfg      | in        | valid / ready             | element_count
//
//  write item: accept, then result register load
//  query item: one table read per scanned level on port a
//  build item: for every level above 0 and every j below n, n the effective element count;
//    read both halves, compare in the shared min unit, write back
//  tready is low while an item is in work or waits for the result register
//  synchronous active-low reset clears control only; table contents are undefined
module sparse_table_range_minimum #(
    parameter int DEPTH  = srmq_pkg::DEPTH_DEF,
    parameter int LEVELS = srmq_pkg::LEVELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave item stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: position[9:0], value[41:10], range_start[51:42], range_end[62:52]
    input  logic [srmq_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [srmq_pkg::IN_USER_W-1:0]       i_s_axis_tuser,
    // master result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: minimum[31:0]
    output logic [srmq_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [srmq_pkg::OUT_USER_W-1:0]      o_m_axis_tuser,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [srmq_pkg::CNT_IN_W-1:0]        i_cfg_data
);
    import srmq_pkg::*;

    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MAW       = LVL_W + ADDR_W;
    localparam int MEM_DEPTH = LEVELS * (1 << ADDR_W);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BRD    = 3'd1;
    localparam logic [2:0] S_BCMP   = 3'd2;
    localparam logic [2:0] S_BWR    = 3'd3;
    localparam logic [2:0] S_QSCAN  = 3'd4;
    localparam logic [2:0] S_QDRAIN = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    // control
    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic                     r_built;
    logic                     n_built;
    logic [CNT_W-1:0]         r_count;
    logic                     r_m_valid;
    logic                     n_m_valid;
    // working registers
    logic [LVL_W-1:0]         r_lvl;
    logic [LVL_W-1:0]         n_lvl;
    logic [CNT_W-1:0]         r_j;
    logic [CNT_W-1:0]         n_j;
    logic                     r_right_ok;
    logic                     n_right_ok;
    logic [LEVELS-1:0]        r_len;
    logic [LEVELS-1:0]        n_len;
    logic [CNT_W-1:0]         r_pos;
    logic [CNT_W-1:0]         n_pos;
    logic                     r_pend;
    logic                     n_pend;
    logic                     r_from_acc;
    logic                     n_from_acc;
    logic signed [DATA_W-1:0] r_res_min;
    logic signed [DATA_W-1:0] n_res_min;
    logic [1:0]               r_res_status;
    logic [1:0]               n_res_status;
    logic signed [DATA_W-1:0] r_m_min;
    logic [1:0]               r_m_status;

    // item fields
    logic [1:0]               w_op;
    logic [9:0]               w_position;
    logic [DATA_W-1:0]        w_value;
    logic [9:0]               w_start;
    logic [10:0]              w_end_raw;
    logic                     w_accept;
    logic                     w_cfg_accept;

    // query decode
    logic signed [31:0]       w_end;
    logic signed [31:0]       w_st;
    logic signed [31:0]       w_cnt;
    logic signed [31:0]       w_qlen;
    logic                     w_q_empty;
    logic                     w_q_invalid;

    // build neighbor
    logic [31:0]              w_right_idx;
    logic                     w_right_in;

    // memory and unit hookup
    logic                     w_we;
    logic [MAW-1:0]           w_waddr;
    logic [DATA_W-1:0]        w_wdata;
    logic [MAW-1:0]           w_raddr_a;
    logic [MAW-1:0]           w_raddr_b;
    logic [DATA_W-1:0]        w_rdata_a;
    logic [DATA_W-1:0]        w_rdata_b;
    t_mu_cmd                  w_cmd;
    logic signed [DATA_W-1:0] w_acc;
    logic                     w_res_load;

    assign w_op       = i_s_axis_tuser[1:0];
    assign w_position = i_s_axis_tdata[9:0];
    assign w_value    = i_s_axis_tdata[41:10];
    assign w_start    = i_s_axis_tdata[51:42];
    assign w_end_raw  = i_s_axis_tdata[62:52];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_accept    = i_cfg_valid && o_cfg_ready;

    assign w_end       = {{21{w_end_raw[10]}}, w_end_raw};
    assign w_st        = {22'd0, w_start};
    assign w_cnt       = 32'(r_count);
    assign w_qlen      = w_end - w_st + 32'sd1;
    assign w_q_empty   = (w_end == w_st - 32'sd1);
    // a length with any bit at or above LEVELS needs a missing level
    assign w_q_invalid = (w_end < w_st - 32'sd1) || (w_end >= w_cnt) ||
                         (w_qlen[31:LEVELS] != '0);

    assign w_right_idx = 32'(r_j) + (32'd1 << (32'(r_lvl) - 32'd1));
    assign w_right_in  = (w_right_idx < 32'(r_count));

    assign w_res_load  = (r_state == S_RESP) && (!r_m_valid || i_m_axis_tready);

    // memory ports
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = {r_lvl, ADDR_W'(r_j)};
        w_wdata   = w_acc;
        w_raddr_a = {r_lvl - LVL_W'(1), ADDR_W'(r_j)};
        w_raddr_b = {r_lvl - LVL_W'(1), ADDR_W'(w_right_idx)};
        if (r_state == S_QSCAN) begin
            w_raddr_a = {r_lvl, ADDR_W'(r_pos)};
        end
        if (w_accept && (w_op == OP_WRITE) && (32'(w_position) < DEPTH)) begin
            w_we    = 1'b1;
            w_waddr = {LVL_W'(0), ADDR_W'(w_position)};
            w_wdata = w_value;
        end else if (r_state == S_BWR) begin
            w_we = 1'b1;
        end
    end

    // shared unit commands
    always_comb begin
        w_cmd.mode = MU_HOLD;
        w_cmd.a    = w_rdata_a;
        w_cmd.b    = r_right_ok ? w_rdata_b : INT_MAX;
        if (r_state == S_BCMP) begin
            w_cmd.mode = MU_PAIR;
        end else if (w_accept && (w_op == OP_QUERY)) begin
            w_cmd.mode = MU_INIT;
        end else if (((r_state == S_QSCAN) || (r_state == S_QDRAIN)) && r_pend) begin
            w_cmd.mode = MU_FOLD;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_built      = r_built;
        n_lvl        = r_lvl;
        n_j          = r_j;
        n_right_ok   = r_right_ok;
        n_len        = r_len;
        n_pos        = r_pos;
        n_pend       = r_pend;
        n_from_acc   = r_from_acc;
        n_res_min    = r_res_min;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid && !i_m_axis_tready;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state      = S_RESP;
                    n_from_acc   = 1'b0;
                    n_res_min    = '0;
                    n_res_status = ST_OK;
                    unique case (w_op)
                        OP_WRITE: begin
                            if (32'(w_position) < DEPTH) begin
                                n_built = 1'b0;
                            end
                        end
                        OP_BUILD: begin
                            if (r_count == '0) begin
                                n_built = 1'b1;
                            end else begin
                                n_lvl   = LVL_W'(1);
                                n_j     = '0;
                                n_state = S_BRD;
                            end
                        end
                        OP_QUERY: begin
                            priority if (!r_built) begin
                                n_res_status = ST_INVALID;
                            end else if (w_q_empty) begin
                                n_res_status = ST_EMPTY;
                                n_res_min    = INT_MAX;
                            end else if (w_q_invalid) begin
                                n_res_status = ST_INVALID;
                            end else begin
                                n_len   = w_qlen[LEVELS-1:0];
                                n_pos   = CNT_W'(w_start);
                                n_lvl   = LVL_W'(LEVELS - 1);
                                n_pend  = 1'b0;
                                n_state = S_QSCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (w_cfg_accept) begin
                    n_built = 1'b0;
                end
            end
            S_BRD: begin
                n_right_ok = w_right_in;
                n_state    = S_BCMP;
            end
            S_BCMP: begin
                n_state = S_BWR;
            end
            S_BWR: begin
                n_state = S_BRD;
                if (r_j + CNT_W'(1) == r_count) begin
                    n_j = '0;
                    if (r_lvl == LVL_W'(LEVELS - 1)) begin
                        n_built = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_lvl = r_lvl + LVL_W'(1);
                    end
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            S_QSCAN: begin
                // one level per cycle, largest piece first
                n_pend = r_len[LEVELS-1];
                if (r_len[LEVELS-1]) begin
                    n_pos = r_pos + (CNT_W'(1) << r_lvl);
                end
                n_len = r_len << 1;
                if (r_lvl == '0) begin
                    n_state = S_QDRAIN;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            S_QDRAIN: begin
                n_pend       = 1'b0;
                n_from_acc   = 1'b1;
                n_res_status = ST_OK;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (w_res_load) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_built   <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_built   <= n_built;
            r_m_valid <= n_m_valid;
            r_pend    <= n_pend;
            if (w_cfg_accept) begin
                r_count <= (32'(i_cfg_data) >= DEPTH) ? CNT_W'(DEPTH) : CNT_W'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl        <= n_lvl;
        r_j          <= n_j;
        r_right_ok   <= n_right_ok;
        r_len        <= n_len;
        r_pos        <= n_pos;
        r_from_acc   <= n_from_acc;
        r_res_min    <= n_res_min;
        r_res_status <= n_res_status;
        if (w_res_load) begin
            r_m_min    <= r_from_acc ? w_acc : r_res_min;
            r_m_status <= r_res_status;
        end
    end

    srmq_table_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .MAW       (MAW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    srmq_min_unit u_min (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_acc (w_acc)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_min;
    assign o_m_axis_tuser  = r_m_status;

    a_cfg_clears_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_accept |=> !r_built)
        else $error("table still marked built after a count write");

    a_write_clears_built: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_WRITE) && (32'(w_position) < DEPTH)) |=> !r_built)
        else $error("table still marked built after an element write");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("effective count above depth");

    a_build_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BRD) || (r_state == S_BCMP) || (r_state == S_BWR)) |->
        ((r_j < r_count) && (r_lvl != '0)))
        else $error("build position outside loaded elements");

    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY)) |->
        (o_m_axis_tdata == INT_MAX))
        else $error("empty range result is not the maximum value");

endmodule

### rtl/core/srmq_table_mem.sv
// sparse table storage: one write port, two registered read ports
module srmq_table_mem #(
    parameter int MEM_DEPTH = 11264,
    parameter int MAW       = 14
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [MAW-1:0]               i_waddr,
    input  logic [srmq_pkg::DATA_W-1:0]  i_wdata,
    input  logic [MAW-1:0]               i_raddr_a,
    input  logic [MAW-1:0]               i_raddr_b,
    output logic [srmq_pkg::DATA_W-1:0]  o_rdata_a,
    output logic [srmq_pkg::DATA_W-1:0]  o_rdata_b
);
    import srmq_pkg::*;

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/srmq_min_unit.sv
// shared signed minimum unit with its accumulator register
module srmq_min_unit (
    input  logic                              i_clk,
    input  srmq_pkg::t_mu_cmd                 i_cmd,
    output logic signed [srmq_pkg::DATA_W-1:0] o_acc
);
    import srmq_pkg::*;

    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] n_acc;
    logic signed [DATA_W-1:0] w_rhs;

    // pair mode compares a with b, fold mode compares a with the accumulator
    assign w_rhs = (i_cmd.mode == MU_FOLD) ? r_acc : i_cmd.b;

    always_comb begin
        unique case (i_cmd.mode)
            MU_INIT: n_acc = INT_MAX;
            MU_PAIR,
            MU_FOLD: n_acc = (i_cmd.a < w_rhs) ? i_cmd.a : w_rhs;
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### verif/sparse_table_range_minimum_test.sv
// self-checking testbench for the sparse-table range-minimum engine
module sparse_table_range_minimum_test;
    import srmq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int LEVELS       = LEVELS_DEF;
    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  position;
        logic [31:0] value;
        logic [9:0]  range_start;
        logic [10:0] range_end;
    } t_rmq_item;

    typedef struct packed {
        logic [31:0] minimum;
        logic [1:0]  status;
    } t_rmq_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // tdata: position[9:0], value[41:10], range_start[51:42], range_end[62:52]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // tuser: op[1:0]
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // tdata: minimum[31:0]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // tuser: status[1:0]
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CNT_IN_W-1:0]   i_cfg_data;

    // local copy of the engine state
    int          level_words [LEVELS][DEPTH];
    bit          table_ready;
    logic [10:0] count_reg;

    t_rmq_result awaited_results [$];

    bit feed_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    int hold_request = 0;
    int items_sent = 0;
    int results_seen = 0;
    int builds_run = 0;
    int mismatches = 0;
    int ok_count = 0;
    int empty_count = 0;
    int flagged_count = 0;
    int cycle_count = 0;

    sparse_table_range_minimum uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // applies one item to the local state and returns the result it must produce
    function automatic t_rmq_result evaluate_item(t_rmq_item it);
        t_rmq_result res;
        int n, first, last, len, pos, acc, half, lvl, j;
        res.minimum = '0;
        res.status  = ST_OK;
        n = (count_reg < DEPTH) ? int'(count_reg) : DEPTH;
        case (it.op)
            OP_WRITE: begin
                level_words[0][it.position] = it.value;
                table_ready = 1'b0;
            end
            OP_BUILD: begin
                for (lvl = 1; lvl < LEVELS; lvl++) begin
                    half = 1 << (lvl - 1);
                    for (j = 0; j < n; j++) begin
                        // neighbor past the loaded elements never wins
                        acc = (j + half < n) ? level_words[lvl-1][j+half] : int'(INT_MAX);
                        level_words[lvl][j] = (level_words[lvl-1][j] < acc) ?
                                              level_words[lvl-1][j] : acc;
                    end
                end
                table_ready = 1'b1;
                builds_run++;
            end
            OP_QUERY: begin
                first = it.range_start;
                last  = $signed(it.range_end);
                if (!table_ready) begin
                    res.status = ST_INVALID;
                end else if (last == first - 1) begin
                    res.minimum = INT_MAX;
                    res.status  = ST_EMPTY;
                end else if (last < first - 1 || last >= n) begin
                    res.status = ST_INVALID;
                end else begin
                    len = last - first + 1;
                    if ((len >> (LEVELS - 1)) > 1) begin
                        res.status = ST_INVALID;
                    end else begin
                        // largest power-of-two piece first
                        pos = first;
                        acc = INT_MAX;
                        for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
                            if (len & (1 << lvl)) begin
                                if (level_words[lvl][pos] < acc) acc = level_words[lvl][pos];
                                pos += 1 << lvl;
                            end
                        end
                        res.minimum = acc;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_rmq_item noise_item();
        t_rmq_item it;
        it.op          = 2'($urandom_range(0, 3));
        it.position    = 10'($urandom);
        it.value       = $urandom;
        it.range_start = 10'($urandom);
        it.range_end   = 11'($urandom);
        return it;
    endfunction

    function automatic t_rmq_item query_item(int first, int last);
        t_rmq_item it;
        it = noise_item();
        it.op          = OP_QUERY;
        it.range_start = 10'(first);
        it.range_end   = 11'(last);
        return it;
    endfunction

    function automatic t_rmq_item write_item(int pos, logic [31:0] val);
        t_rmq_item it;
        it = noise_item();
        it.op       = OP_WRITE;
        it.position = 10'(pos);
        it.value    = val;
        return it;
    endfunction

    function automatic t_rmq_item op_item(logic [1:0] op);
        t_rmq_item it;
        it = noise_item();
        it.op = op;
        return it;
    endfunction

    function automatic logic [31:0] element_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return INT_MAX;
            2: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, $signed(want), $signed(got));
        end
    endtask

    task automatic send_item(t_rmq_item it);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.op;
        i_s_axis_tdata  <= {1'b0, it.range_end, it.range_start, it.value, it.position};
        do @(posedge i_clk); while (!o_s_axis_tready);
        awaited_results.push_back(evaluate_item(it));
        items_sent++;
    endtask

    // the block is idle once every result is back
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_element_count(int count);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 11'(count);
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg   = 11'(count);
        table_ready = 1'b0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_elements(int n);
        int p;
        for (p = 0; p < n; p++) send_item(write_item(p, element_value()));
    endtask

    task automatic test_unbuilt_table();
        t_rmq_item it;
        send_item(query_item(0, 0));
        it = '1;
        it.op = OP_NONE;
        send_item(it);
    endtask

    task automatic test_small_table();
        set_element_count(6);
        send_item(write_item(0, 32'sd5));
        send_item(write_item(1, INT_MAX));
        send_item(write_item(2, -32'sd1));
        send_item(write_item(3, 32'h8000_0000));
        send_item(write_item(4, 32'sd0));
        send_item(write_item(5, 32'sd7));
        send_item(op_item(OP_BUILD));
        send_item(query_item(0, 5));
        send_item(query_item(1, 1));
        send_item(query_item(4, 5));
        send_item(query_item(0, -1));
        send_item(query_item(3, 2));
        send_item(query_item(5, 3));
        send_item(query_item(2, 6));
        send_item(query_item(0, -1024));
        // a write leaves the table stale until the next build
        send_item(write_item(2, -32'sd100));
        send_item(query_item(0, 2));
        send_item(op_item(OP_BUILD));
        send_item(query_item(0, 2));
    endtask

    task automatic test_count_extremes();
        set_element_count(0);
        send_item(op_item(OP_BUILD));
        send_item(query_item(0, -1));
        send_item(query_item(0, 0));
        // count above depth is clipped to depth
        set_element_count(2047);
        load_elements(DEPTH);
        send_item(op_item(OP_BUILD));
        send_item(query_item(0, 1023));
        send_item(query_item(512, 1023));
        send_item(query_item(1023, 1023));
        send_item(query_item(700, 1022));
        send_item(query_item(1, 1023));
        set_element_count(1024);
        send_item(op_item(OP_BUILD));
        send_item(query_item(0, 1023));
        send_item(query_item(300, 811));
    endtask

    task automatic test_output_stall();
        int k;
        feed_gaps    = 1'b0;
        hold_request = 300;
        for (k = 0; k < 12; k++) send_item(query_item(k * 40, k * 41 + 1));
        wait_idle();
        feed_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        int n, phase, slots, pick, first, last, k, base;
        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            feed_gaps = (phase % 5 != 0) && ($urandom_range(0, 3) != 0);
            sink_gaps = (phase % 5 != 0) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 15);
            if (pick == 0) n = 0;
            else if (pick == 1) n = $urandom_range(65, 256);
            else n = $urandom_range(1, 64);
            set_element_count(n);
            load_elements(n);
            send_item(op_item(OP_BUILD));
            slots = $urandom_range(15, 40);
            for (k = 0; k < slots; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 68 && n > 0) begin
                    first = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 3))
                        0: last = first;
                        1: last = n - 1;
                        default: last = $urandom_range(first, n - 1);
                    endcase
                    send_item(query_item(first, last));
                end else if (pick < 76) begin
                    first = $urandom_range(0, (n < DEPTH) ? n : DEPTH - 1);
                    send_item(query_item(first, first - 1));
                end else if (pick < 84) begin
                    send_item(query_item($urandom, $urandom));
                end else if (pick < 88) begin
                    first = $urandom_range(2, DEPTH - 1);
                    send_item(query_item(first, first - 2 - int'($urandom_range(0, first))));
                end else if (pick < 93) begin
                    send_item(write_item($urandom_range(0, DEPTH - 1), element_value()));
                end else if (pick < 97) begin
                    send_item(op_item(OP_BUILD));
                end else begin
                    send_item(op_item(OP_NONE));
                end
            end
            phase++;
        end
        feed_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // result side: random stalls per transaction, long hold-off on request
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = 0;
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end else if (sink_gaps) begin
                stall = $urandom_range(0, 11);
            end
            @(negedge i_clk);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rmq_result want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result minimum", '0, o_m_axis_tdata);
            end else begin
                want = awaited_results.pop_front();
                if (o_m_axis_tdata !== want.minimum)
                    report_mismatch("minimum", want.minimum, o_m_axis_tdata);
                if (o_m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_m_axis_tuser));
                if (want.status == ST_EMPTY) empty_count++;
                else if (want.status == ST_INVALID) flagged_count++;
                else ok_count++;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_NONE;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        count_reg       = '0;
        table_ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unbuilt_table();
        test_small_table();
        test_count_extremes();
        test_output_stall();
        test_random_mix();

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("%0d items sent, %0d results checked, %0d table builds, counts 0 to 2047",
                 items_sent, results_seen, builds_run);
        $display("status ok %0d, empty range %0d, flagged %0d, mismatches %0d",
                 ok_count, empty_count, flagged_count, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
